>>> hdl/ptw_pkg.sv
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared types and constants for the two-level page table walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

	localparam int unsigned VA_W     = 32;
	localparam int unsigned PA_W     = 32;
	localparam int unsigned PPN_W    = 20;
	localparam int unsigned VPN_W    = 10;
	localparam int unsigned OFFSET_W = 12;
	localparam int unsigned PTE_W    = 32;

	// page table entry bit positions
	localparam int unsigned PTE_V = 0;
	localparam int unsigned PTE_R = 1;
	localparam int unsigned PTE_W_BIT = 2;
	localparam int unsigned PTE_X = 3;

	typedef enum logic [0:0] {
		CMD_TRANSLATE = 1'b0,
		CMD_MEM_RSP   = 1'b1
	} command_t;

	typedef enum logic [1:0] {
		ACC_FETCH   = 2'd0,
		ACC_READ    = 2'd1,
		ACC_WRITE   = 2'd2,
		ACC_UNKNOWN = 2'd3
	} access_t;

	typedef enum logic [0:0] {
		RES_MEM_READ = 1'b0,
		RES_DONE     = 1'b1
	} result_kind_t;

	typedef enum logic [2:0] {
		FAULT_NONE = 3'd0,
		FAULT_DIR  = 3'd1,
		FAULT_LEAF = 3'd2,
		FAULT_PERM = 3'd3,
		FAULT_KIND = 3'd4
	} fault_t;

	typedef enum logic [1:0] {
		PHASE_IDLE = 2'd0,
		PHASE_DIR  = 2'd1,
		PHASE_LEAF = 2'd2
	} phase_t;

	typedef struct packed {
		logic              command;
		logic [VA_W-1:0]   virtual_address;
		logic [1:0]        access_kind;
		logic [PTE_W-1:0]  read_data;
	} req_t;

	typedef struct packed {
		logic              result_kind;
		logic [PA_W-1:0]   address;
		logic [2:0]        fault;
	} rsp_t;

endpackage

>>> hdl/ptw_if.sv
// ----------------------------------------------------------------------------
// ptw channel interfaces
// Request, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ptw_req_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [31:0] virtual_address;
	logic [1:0]  access_kind;
	logic [31:0] read_data;

	modport source (output valid, command, virtual_address, access_kind, read_data,
		input ready);
	modport sink (input valid, command, virtual_address, access_kind, read_data,
		output ready);
endinterface

interface ptw_rsp_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [31:0] address;
	logic [2:0]  fault;

	modport source (output valid, result_kind, address, fault, input ready);
	modport sink (input valid, result_kind, address, fault, output ready);
endinterface

interface ptw_cfg_if;
	logic        valid;
	logic        ready;
	logic [19:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

>>> hdl/two_level_page_table_walker_unit.sv
// ----------------------------------------------------------------------------
// two_level_page_table_walker_unit
// Two-level page table walker with registered input and result stages.
// ----------------------------------------------------------------------------
// Each request or memory-response beat is captured in an input register,
// resolved against the walk state, and the result (read request
// or finished translation) lands in an output register. One beat is taken per
// cycle, set by the single walk step between those two registers, while a beat
// that yields a result is held until the output register is free. Requests
// arriving mid-walk and responses arriving while idle are dropped with no
// result. The root table page is written on the cfg channel and sampled when a
// request is resolved, so write it only while no walk is in flight.
module two_level_page_table_walker_unit
	import ptw_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	ptw_req_if.sink   req,
	ptw_rsp_if.source rsp,
	ptw_cfg_if.sink   cfg
);

	logic             root_we;
	logic [PPN_W-1:0] root_q;
	logic             valid_s1;
	req_t             item_s1;
	logic             out_valid_q;
	rsp_t             out_q;
	logic             has_result;
	rsp_t             result;
	logic             out_free;
	logic             adv_s1;
	logic             take_in;

	assign cfg.ready = 1'b1;
	assign root_we   = cfg.valid & cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) root_q <= '0;
		else if (root_we) root_q <= cfg.data;
	end

	assign out_free  = !out_valid_q || rsp.ready;
	assign adv_s1    = valid_s1 && (!has_result || out_free);
	assign take_in   = req.valid && req.ready;
	assign req.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (req.ready) valid_s1 <= req.valid;
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1.command         <= req.command;
			item_s1.virtual_address <= req.virtual_address;
			item_s1.access_kind     <= req.access_kind;
			item_s1.read_data       <= req.read_data;
		end
	end

	ptw_step u_step (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (adv_s1),
		.item            (item_s1),
		.root_table_page (root_q),
		.has_result      (has_result),
		.result          (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (out_free) out_valid_q <= adv_s1 && has_result;
	end

	always_ff @(posedge clk) begin
		if (out_free && adv_s1 && has_result) out_q <= result;
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.result_kind = out_q.result_kind;
	assign rsp.address     = out_q.address;
	assign rsp.fault       = out_q.fault;

endmodule

>>> hdl/ptw_step.sv
// ----------------------------------------------------------------------------
// ptw_step
// Walk state machine: consumes one registered beat per enable and forms the
// matching result, if any.
// ----------------------------------------------------------------------------
module ptw_step
	import ptw_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  req_t             item,
	input  logic [PPN_W-1:0] root_table_page,
	output logic             has_result,
	output rsp_t             result
);

	phase_t              phase_q, phase_nxt;
	logic [VA_W-1:0]     held_address_q;
	logic [1:0]          held_access_q;
	logic                grant;
	logic                leaf_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PHASE_IDLE;
			held_address_q <= '0;
			held_access_q  <= '0;
		end else if (en) begin
			phase_q <= phase_nxt;
			if (item.command == CMD_TRANSLATE && phase_q == PHASE_IDLE) begin
				held_address_q <= item.virtual_address;
				held_access_q  <= item.access_kind;
			end
		end
	end

	// next state
	always_comb begin
		phase_nxt = phase_q;
		unique case (phase_q)
			PHASE_IDLE: begin
				if (item.command == CMD_TRANSLATE) phase_nxt = PHASE_DIR;
			end
			PHASE_DIR: begin
				if (item.command == CMD_MEM_RSP)
					phase_nxt = item.read_data[PTE_V] ? PHASE_LEAF : PHASE_IDLE;
			end
			PHASE_LEAF: begin
				if (item.command == CMD_MEM_RSP) phase_nxt = PHASE_IDLE;
			end
			default: begin
				phase_nxt = (item.command == CMD_TRANSLATE) ? PHASE_DIR : PHASE_IDLE;
			end
		endcase
	end

	always_comb begin
		unique case (access_t'(held_access_q))
			ACC_FETCH: grant = item.read_data[PTE_X];
			ACC_READ:  grant = item.read_data[PTE_R];
			ACC_WRITE: grant = item.read_data[PTE_W_BIT];
			default:   grant = 1'b0;
		endcase
	end

	assign leaf_ok = item.read_data[PTE_V];

	// outputs
	always_comb begin
		has_result         = 1'b0;
		result.result_kind = RES_MEM_READ;
		result.address     = '0;
		result.fault       = FAULT_NONE;
		unique case (phase_q)
			PHASE_DIR: begin
				if (item.command == CMD_MEM_RSP) begin
					has_result = 1'b1;
					if (!item.read_data[PTE_V]) begin
						result.result_kind = RES_DONE;
						result.fault       = FAULT_DIR;
					end else begin
						result.address = {item.read_data[PTE_W-1 -: PPN_W],
							held_address_q[VA_W-VPN_W-1 -: VPN_W], 2'b00};
					end
				end
			end
			PHASE_LEAF: begin
				if (item.command == CMD_MEM_RSP) begin
					has_result         = 1'b1;
					result.result_kind = RES_DONE;
					priority if (!leaf_ok) begin
						result.fault = FAULT_LEAF;
					end else if (held_access_q == ACC_UNKNOWN) begin
						result.fault = FAULT_KIND;
					end else if (!grant) begin
						result.fault = FAULT_PERM;
					end else begin
						result.address = {item.read_data[PTE_W-1 -: PPN_W],
							held_address_q[OFFSET_W-1:0]};
					end
				end
			end
			default: begin
				// idle: only a translate request answers
				if (item.command == CMD_TRANSLATE) begin
					has_result     = 1'b1;
					result.address = {root_table_page,
						item.virtual_address[VA_W-1 -: VPN_W], 2'b00};
				end
			end
		endcase
	end

endmodule
